// ===== hw/rtl/geoenc_pkg.sv =====
// geoenc_pkg: shared types and constants of the geohash encoder
// holds the coordinate span limits, the base-32 alphabet and the stage control struct
// no dependencies

package geoenc_pkg;

   // full-range limits of the fixed-point coordinates
   localparam logic signed [31:0] LAT_LO = -32'sd1073741824;
   localparam logic signed [31:0] LAT_HI = 32'sd1073741824;
   localparam logic signed [32:0] LON_LO = -33'sd2147483648;
   localparam logic signed [32:0] LON_HI = 33'sd2147483648;

   // widths of the offset values that carry the bisection bits
   localparam int LAT_VW = 31;
   localparam int LON_VW = 32;

   // ascii codes of digits plus lowercase letters without a, i, l, o
   localparam logic [6:0] GEO_ALPHABET [32] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
      7'h68, 7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
      7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
   };

   // control that travels with an item between front pipeline and serializer
   typedef struct packed {
      logic       valid;
      logic [3:0] count;
   } ctl_type;

endpackage

// ===== hw/rtl/geoenc_front.sv =====
// geoenc_front: three-stage pipeline that turns a coordinate pair into its code word
// stages: clamp, offset from the low end, decrement and bit interleave; uses geoenc_pkg

module geoenc_front #(
   parameter int MAX_CHARS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [31:0]        latitude,
   input  logic signed [32:0]        longitude,
   input  logic [3:0]                count,
   output geoenc_pkg::ctl_type       out_ctl,
   output logic [5*MAX_CHARS-1:0]    out_code,
   input  logic                      out_ready
);

   localparam int CODE_W   = 5 * MAX_CHARS;
   localparam int LON_BITS = (CODE_W + 1) / 2;
   localparam int LAT_BITS = CODE_W / 2;

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   // stage payloads
   logic signed [31:0] s1_lat_ff, s1_lat_in;
   logic signed [32:0] s1_lon_ff, s1_lon_in;
   logic [3:0]         s1_cnt_ff, s2_cnt_ff, s3_cnt_ff;
   logic [31:0]        s2_lat_ff, s2_lat_in;
   logic [32:0]        s2_lon_ff, s2_lon_in;
   logic [CODE_W-1:0]  s3_code_ff, s3_code_in;
   logic [geoenc_pkg::LAT_VW-1:0] lat_v;
   logic [geoenc_pkg::LON_VW-1:0] lon_v;

   // stall chain: a stage moves on when its successor has room
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: clamp to the full interval
   always_comb begin
      if (latitude < geoenc_pkg::LAT_LO) begin
         s1_lat_in = geoenc_pkg::LAT_LO;
      end else if (latitude > geoenc_pkg::LAT_HI) begin
         s1_lat_in = geoenc_pkg::LAT_HI;
      end else begin
         s1_lat_in = latitude;
      end
      if (longitude < geoenc_pkg::LON_LO) begin
         s1_lon_in = geoenc_pkg::LON_LO;
      end else if (longitude > geoenc_pkg::LON_HI) begin
         s1_lon_in = geoenc_pkg::LON_HI;
      end else begin
         s1_lon_in = longitude;
      end
   end

   // stage 2: offset from the low end of the interval
   assign s2_lat_in = s1_lat_ff - geoenc_pkg::LAT_LO;
   assign s2_lon_in = s1_lon_ff - geoenc_pkg::LON_LO;

   // stage 3: minus one so a midpoint tie goes low
   always_comb begin
      lat_v = (s2_lat_ff == '0) ? '0 : geoenc_pkg::LAT_VW'(s2_lat_ff - 32'd1);
      lon_v = (s2_lon_ff == '0) ? '0 : geoenc_pkg::LON_VW'(s2_lon_ff - 33'd1);
   end

   // stage 3: interleave bisection bits, longitude first
   always_comb begin
      s3_code_in = '0;
      for (int i = 0; i < LON_BITS; i++) begin
         s3_code_in[CODE_W-1-2*i] = lon_v[geoenc_pkg::LON_VW-1-i];
      end
      for (int i = 0; i < LAT_BITS; i++) begin
         s3_code_in[CODE_W-2-2*i] = lat_v[geoenc_pkg::LAT_VW-1-i];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_lat_ff <= s1_lat_in;
         s1_lon_ff <= s1_lon_in;
         s1_cnt_ff <= count;
      end
      if (s2_ready) begin
         s2_lat_ff <= s2_lat_in;
         s2_lon_ff <= s2_lon_in;
         s2_cnt_ff <= s1_cnt_ff;
      end
      if (s3_ready) begin
         s3_code_ff <= s3_code_in;
         s3_cnt_ff  <= s2_cnt_ff;
      end
   end

   assign out_ctl.valid = s3_valid_ff;
   assign out_ctl.count = s3_cnt_ff;
   assign out_code      = s3_code_ff;

endmodule

// ===== hw/rtl/geoenc_serial.sv =====
// geoenc_serial: emits one base-32 character of a code word per cycle
// takes the next item on the cycle of the last character; uses geoenc_pkg

module geoenc_serial #(
   parameter int MAX_CHARS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  geoenc_pkg::ctl_type       in_ctl,
   input  logic [5*MAX_CHARS-1:0]    in_code,
   output logic                      in_ready,
   output logic                      strobe,
   output logic [6:0]                char_code,
   output logic [3:0]                char_position,
   output logic                      last_char
);

   localparam int CODE_W = 5 * MAX_CHARS;

   logic              valid_ff;
   logic [CODE_W-1:0] code_ff;
   logic [3:0]        pos_ff;
   logic [3:0]        last_pos_ff;
   logic              at_last;

   assign at_last  = (pos_ff == last_pos_ff);
   assign in_ready = !valid_ff || at_last;

   // state of the character currently shown
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         code_ff     <= in_code;
         pos_ff      <= '0;
         last_pos_ff <= in_ctl.count - 4'd1;
      end else begin
         code_ff <= code_ff << 5;
         pos_ff  <= pos_ff + 4'd1;
      end
   end

   // result ports
   assign strobe        = valid_ff;
   assign char_code     = geoenc_pkg::GEO_ALPHABET[code_ff[CODE_W-1 -: 5]];
   assign char_position = pos_ff;
   assign last_char     = at_last;

endmodule

// ===== hw/rtl/geohash_encoder_top.sv =====
// geohash_encoder_top: geohash base-32 encoder, top level
// instantiates geoenc_front and geoenc_serial; uses geoenc_pkg
//
// usage:
//   an item (req_latitude, req_longitude) is taken at a clock edge with start
//   high and busy low. latitude is in units of 90/2^30 degrees, longitude in
//   units of 180/2^31 degrees; values outside the full interval act as clamped.
//   the item yields char_count characters, one per cycle on rsp_strobe, with
//   rsp_char_position counting from 0 and rsp_last_char on the final one.
//   csr_wr_en with csr_wr_data writes char_count (0 acts as 1, above
//   MAX_CHARS acts as MAX_CHARS); write it only while the block is idle.
//   the first character reaches the result ports after the item has passed
//   the front stage registers s1, s2, s3 and then the serializer register.
//   throughput is set by the single-character result channel; the
//   three-stage front pipeline holds up to three items while the serializer
//   drains, so busy rises only when all stages are full.
//   reset clears every valid bit and sets char_count to 12.
//   the receiver cannot stall: each character is valid for one cycle only.

module geohash_encoder_top #(
   parameter int MAX_CHARS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_latitude,
   input  logic signed [32:0] req_longitude,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data,
   output logic               rsp_strobe,
   output logic [6:0]         rsp_char_code,
   output logic [3:0]         rsp_char_position,
   output logic               rsp_last_char
);

   localparam int CODE_W = 5 * MAX_CHARS;

   logic [3:0]          char_count_ff;
   logic [3:0]          count_eff;
   logic                front_ready;
   logic                serial_ready;
   geoenc_pkg::ctl_type front_ctl;
   logic [CODE_W-1:0]   front_code;

   // character count register
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= 4'd12;
      end else if (csr_wr_en) begin
         char_count_ff <= csr_wr_data;
      end
   end

   // legal count range
   always_comb begin
      if (char_count_ff == 4'd0) begin
         count_eff = 4'd1;
      end else if (char_count_ff > 4'(MAX_CHARS)) begin
         count_eff = 4'(MAX_CHARS);
      end else begin
         count_eff = char_count_ff;
      end
   end

   assign busy = !front_ready;

   geoenc_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_ready  (front_ready),
      .latitude  (req_latitude),
      .longitude (req_longitude),
      .count     (count_eff),
      .out_ctl   (front_ctl),
      .out_code  (front_code),
      .out_ready (serial_ready)
   );

   geoenc_serial #(
      .MAX_CHARS (MAX_CHARS)
   ) u_serial (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (front_ctl),
      .in_code       (front_code),
      .in_ready      (serial_ready),
      .strobe        (rsp_strobe),
      .char_code     (rsp_char_code),
      .char_position (rsp_char_position),
      .last_char     (rsp_last_char)
   );

endmodule
